### rtl/core/tanhpq_pkg.sv
// tanhpq_pkg.sv: segment table, types and binary32 helper functions
`timescale 1ns / 1ps
package tanhpq_pkg;

    localparam int SEGMENT_COUNT = 31;
    localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [31:0] LAST_HI  = 32'h4108_0000;

    localparam logic [31:0] SEG_LO [SEGMENT_COUNT] = '{
        32'h00000000, 32'h3b23d70a, 32'h3ba3d70a, 32'h3bf5c28f, 32'h3c23d70a, 32'h3c75c28f,
        32'h3ccccccd, 32'h3d23d70a, 32'h3d4ccccc, 32'h3d851eb8, 32'h3da3d70a, 32'h3dcccccd,
        32'h3e000000, 32'h3e3851ec, 32'h3e6147ae, 32'h3e99999a, 32'h3ecccccd, 32'h3f000000,
        32'h3f333333, 32'h3f666666, 32'h3f8ccccd, 32'h3fa66666, 32'h3fc00000, 32'h3fe00000,
        32'h3ff33333, 32'h400ccccd, 32'h40266666, 32'h404ccccd, 32'h40800000, 32'h40a00000,
        32'h40d80000};
    localparam logic [31:0] SEG_HI [SEGMENT_COUNT] = '{
        32'h3b23d70a, 32'h3ba3d70a, 32'h3bf5c28f, 32'h3c23d70a, 32'h3c75c28f, 32'h3ccccccd,
        32'h3d23d70a, 32'h3d4ccccc, 32'h3d851eb8, 32'h3da3d70a, 32'h3dcccccd, 32'h3e000000,
        32'h3e3851ec, 32'h3e6147ae, 32'h3e99999a, 32'h3ecccccd, 32'h3f000000, 32'h3f333333,
        32'h3f666666, 32'h3f8ccccd, 32'h3fa66666, 32'h3fc00000, 32'h3fe00000, 32'h3ff33333,
        32'h400ccccd, 32'h40266666, 32'h404ccccd, 32'h40800000, 32'h40a00000, 32'h40d80000,
        32'h41080000};
    localparam logic [31:0] SEG_A [SEGMENT_COUNT] = '{
        32'hbaa3caee, 32'hbb75c04e, 32'hbbccca36, 32'hbc0f5831, 32'hbc4cc199, 32'hbca3c083,
        32'hbd04edaa, 32'hbd37d20c, 32'hbd6a7a5e, 32'hbd937076, 32'hbdb65529, 32'hbde28895,
        32'hbe175938, 32'hbe423259, 32'hbe735b9e, 32'hbe988e3e, 32'hbeb16036, 32'hbec306ba,
        32'hbebdb3b4, 32'hbea3a3f1, 32'hbe823920, 32'hbe442924, 32'hbe088aea, 32'hbdc03d01,
        32'hbd7f8118, 32'hbd03d573, 32'hbc48f27e, 32'hbb4c28c2, 32'hba0adcf7, 32'hb82405dd,
        32'hb59e81d0};
    localparam logic [31:0] SEG_B [SEGMENT_COUNT] = '{
        32'h3f80000a, 32'h3f800073, 32'h3f800145, 32'h3f800280, 32'h3f800514, 32'h3f800cef,
        32'h3f80222b, 32'h3f8041ec, 32'h3f806b41, 32'h3f80aa10, 32'h3f81047d, 32'h3f81934c,
        32'h3f82d23c, 32'h3f84b6f1, 32'h3f87828f, 32'h3f8c2d35, 32'h3f9119e2, 32'h3f95909e,
        32'h3f937c63, 32'h3f87a814, 32'h3f6a85d2, 32'h3f40cc30, 32'h3f13eb04, 32'h3ee214f5,
        32'h3ea40ed3, 32'h3e3fdee5, 32'h3dab3975, 32'h3cd1c4e6, 32'h3bae12fa, 32'h3a0390df,
        32'h37a1d096};
    localparam logic [31:0] SEG_C [SEGMENT_COUNT] = '{
        32'haf8dea53, 32'hb28ce058, 32'hb3aa8988, 32'hb46cc774, 32'hb52a7c64, 32'hb62c0e66,
        32'hb73956e3, 32'hb7fbad63, 32'hb8827d60, 32'hb902abf0, 32'hb9780391, 32'hb9ef8bef,
        32'hba8f8dd0, 32'hbb1da4cd, 32'hbba05bc1, 32'hbc2ab7ca, 32'hbc9404a5, 32'hbcdc7106,
        32'hbca8f22f, 32'h3caf3468, 32'h3dcdfde6, 32'h3e53689d, 32'h3ead52a7, 32'h3ee98742,
        32'h3f129a90, 32'h3f3828ab, 32'h3f5acac9, 32'h3f725aea, 32'h3f7c9037, 32'h3f7f963a,
        32'h3f7ffad5};

    // unrounded value: sgn * m * 2^e
    typedef struct packed {
        logic               sgn;
        logic [47:0]        m;
        logic signed [10:0] e;
    } fp_raw_t;

    typedef struct packed {
        logic [23:0] m;
        logic [7:0]  e;
    } fp_unp_t;

    function automatic fp_unp_t fp_unpack(logic [31:0] v);
        fp_unp_t u;
        if (v[30:23] == 8'd0)
        begin
            u.m = {1'b0, v[22:0]};
            u.e = 8'd1;
        end
        else
        begin
            u.m = {1'b1, v[22:0]};
            u.e = v[30:23];
        end
        return u;
    endfunction

    // round to nearest even, with subnormal and overflow handling
    function automatic logic [31:0] fp_pack(fp_raw_t x);
        logic [5:0]         len;
        logic signed [11:0] ew;
        logic signed [11:0] q;
        logic signed [11:0] s;
        logic [5:0]         sh;
        logic [97:0]        t;
        logic [47:0]        r;
        logic [33:0]        bits;
        logic [31:0]        res;
        len = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (x.m[i])
                len = 6'(i + 1);
        end
        ew = {x.e[10], x.e};
        q = $signed({6'b0, len}) + ew - 12'sd24;
        if (q < -12'sd149)
            q = -12'sd149;
        s = q - ew;
        if (s <= 12'sd0)
        begin
            r = x.m << 6'(-s);
        end
        else
        begin
            sh = (s > 12'sd50) ? 6'd50 : s[5:0];
            t = {x.m, 50'b0} >> sh;
            r = t[97:50];
            if (t[49] && ((t[48:0] != 49'd0) || r[0]))
                r = r + 48'd1;
        end
        bits = (34'($unsigned(q + 12'sd149)) << 23) + 34'(r);
        if (bits >= 34'h07F800000)
            bits = 34'h07F800000;
        res = {x.sgn, bits[30:0]};
        if (x.m == 48'd0)
            res = {x.sgn, 31'd0};
        return res;
    endfunction

    function automatic fp_raw_t fp_mul_raw(logic [31:0] a, logic [31:0] b);
        fp_unp_t ua;
        fp_unp_t ub;
        fp_raw_t x;
        ua = fp_unpack(a);
        ub = fp_unpack(b);
        x.sgn = a[31] ^ b[31];
        x.m = 48'(ua.m) * 48'(ub.m);
        x.e = $signed({3'b0, ua.e}) + $signed({3'b0, ub.e}) - 11'sd300;
        return x;
    endfunction

    function automatic fp_raw_t fp_add_raw(logic [31:0] a, logic [31:0] b);
        fp_unp_t ua;
        fp_unp_t ub;
        fp_unp_t tu;
        logic    sa;
        logic    sb;
        logic    ts;
        logic [7:0]  d;
        logic [5:0]  dc;
        logic [26:0] ma;
        logic [26:0] mb;
        logic [66:0] t;
        logic [27:0] m;
        fp_raw_t x;
        ua = fp_unpack(a);
        ub = fp_unpack(b);
        sa = a[31];
        sb = b[31];
        if (ub.e > ua.e)
        begin
            tu = ua; ua = ub; ub = tu;
            ts = sa; sa = sb; sb = ts;
        end
        ma = {ua.m, 3'b0};
        d = ua.e - ub.e;
        dc = (d >= 8'd40) ? 6'd40 : d[5:0];
        t = {ub.m, 3'b0, 40'b0} >> dc;
        mb = t[66:40] | {26'd0, |t[39:0]};
        if (sa == sb)
        begin
            m = {1'b0, ma} + {1'b0, mb};
            x.sgn = sa;
        end
        else if (ma >= mb)
        begin
            m = {1'b0, ma - mb};
            x.sgn = sa;
        end
        else
        begin
            m = {1'b0, mb - ma};
            x.sgn = sb;
        end
        // exact zero: +0 unless both addends are -0
        if (m == 28'd0)
            x.sgn = (sa == sb) ? sa : 1'b0;
        x.m = 48'(m);
        x.e = $signed({3'b0, ua.e}) - 11'sd153;
        return x;
    endfunction

endpackage

### rtl/core/tanh_piecewise_quadratic_f32_top.sv
// tanh_piecewise_quadratic_f32_top.sv: pipelined piecewise quadratic tanh on binary32
// stages 1 to 6 feed the output register, which is stage 7
// throughput: one item per cycle; every stage advances together when the output
// register is empty or being taken, so a stalled result holds the whole pipe
// the depth is set by the three dependent rounds of multiply or add, each split
// into a raw stage and a round/pack stage
// reset: asynchronous active low, clears all stage valid bits; payload is not reset
`timescale 1ns / 1ps
module tanh_piecewise_quadratic_f32_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] x_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] y_bits
);
    import tanhpq_pkg::*;

    logic en;

    // stage 1: segment select
    logic        v1_reg, hit1_reg, neg1_reg;
    logic [31:0] x1_reg, a1_reg, b1_reg, c1_reg;
    logic        hit1_next;
    logic [31:0] a1_next, b1_next, c1_next, mag;

    // stage 2: raw x*x and x*b
    logic        v2_reg, hit2_reg, neg2_reg;
    logic [31:0] a2_reg, c2_reg;
    fp_raw_t     xx2_reg, xb2_reg;

    // stage 3: rounded x2, bx
    logic        v3_reg, hit3_reg, neg3_reg;
    logic [31:0] a3_reg, c3_reg, x2_3_reg, bx3_reg;

    // stage 4: raw a*x2 and c+bx
    logic        v4_reg, hit4_reg, neg4_reg;
    fp_raw_t     ax4_reg, cb4_reg;

    // stage 5: rounded ax2, bxc
    logic        v5_reg, hit5_reg, neg5_reg;
    logic [31:0] ax5_reg, cb5_reg;

    // stage 6: raw final sum
    logic        v6_reg, hit6_reg, neg6_reg;
    fp_raw_t     sum6_reg;

    // stage 7: output register
    logic        v7_reg;
    logic [31:0] y7_reg, y7_next;

    assign en       = !v7_reg || out_ready;
    assign in_ready = en;
    assign mag      = x_bits & MAG_MASK;

    always_comb
    begin
        hit1_next = 1'b0;
        a1_next   = 32'd0;
        b1_next   = 32'd0;
        c1_next   = 32'd0;
        for (int i = 0; i < SEGMENT_COUNT; i++)
        begin
            if (!hit1_next && mag >= SEG_LO[i] && mag < SEG_HI[i])
            begin
                hit1_next = 1'b1;
                a1_next   = SEG_A[i];
                b1_next   = SEG_B[i];
                c1_next   = SEG_C[i];
            end
        end
    end

    always_comb
    begin
        y7_next = hit6_reg ? fp_pack(sum6_reg) : ONE_BITS;
        y7_next[31] = y7_next[31] ^ neg6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= hit1_next;
            neg1_reg <= x_bits[31];
            x1_reg   <= mag;
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            c1_reg   <= c1_next;

            hit2_reg <= hit1_reg;
            neg2_reg <= neg1_reg;
            a2_reg   <= a1_reg;
            c2_reg   <= c1_reg;
            xx2_reg  <= fp_mul_raw(x1_reg, x1_reg);
            xb2_reg  <= fp_mul_raw(x1_reg, b1_reg);

            hit3_reg <= hit2_reg;
            neg3_reg <= neg2_reg;
            a3_reg   <= a2_reg;
            c3_reg   <= c2_reg;
            x2_3_reg <= fp_pack(xx2_reg);
            bx3_reg  <= fp_pack(xb2_reg);

            hit4_reg <= hit3_reg;
            neg4_reg <= neg3_reg;
            ax4_reg  <= fp_mul_raw(a3_reg, x2_3_reg);
            cb4_reg  <= fp_add_raw(c3_reg, bx3_reg);

            hit5_reg <= hit4_reg;
            neg5_reg <= neg4_reg;
            ax5_reg  <= fp_pack(ax4_reg);
            cb5_reg  <= fp_pack(cb4_reg);

            hit6_reg <= hit5_reg;
            neg6_reg <= neg5_reg;
            sum6_reg <= fp_add_raw(ax5_reg, cb5_reg);

            y7_reg   <= y7_next;
        end
    end

    assign out_valid = v7_reg;
    assign y_bits    = y7_reg;

    // a selected segment always lies below the saturation bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && hit1_reg) |-> (x1_reg < LAST_HI))
        else $error("segment hit above saturation bound");

    // magnitudes past the table give exactly one in magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && v6_reg && !hit6_reg) |=> (y_bits[30:0] == ONE_BITS[30:0]))
        else $error("saturated item not one");

    // a stall freezes the stage valid bits, checked here on stages 1, 4 and 6
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(v4_reg) && $stable(v6_reg)))
        else $error("pipeline moved during stall");

endmodule

### dv/tb.sv
// tb.sv: self-checking testbench for the piecewise quadratic tanh pipeline
`timescale 1ns / 1ps
module tb;
    import tanhpq_pkg::SEGMENT_COUNT;
    import tanhpq_pkg::SEG_LO;
    import tanhpq_pkg::SEG_HI;
    import tanhpq_pkg::SEG_A;
    import tanhpq_pkg::SEG_B;
    import tanhpq_pkg::SEG_C;
    import tanhpq_pkg::ONE_BITS;
    import tanhpq_pkg::MAG_MASK;

    localparam logic [31:0] NO_CHECK = 32'hFFFF_FFFF;
    localparam int          N_RANDOM = 1500;
    localparam int          DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] x_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] y_bits;

    logic [31:0] tanh_queue[$];
    int          n_errors;
    bit          send_done;
    bit          long_hold;

    tanh_piecewise_quadratic_f32_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_bits    (x_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .y_bits    (y_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // binary32 rounding of sgn * m * 2^e, nearest even
    function automatic logic [31:0] round_f32(logic sgn, logic [63:0] m, int e);
        int          len;
        int          q;
        int          s;
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        if (m == 0)
            return {sgn, 31'd0};
        len = 0;
        for (int i = 0; i < 64; i++)
            if (m[i])
                len = i + 1;
        q = len + e - 24;
        if (q < -149)
            q = -149;
        s = q - e;
        if (s <= 0)
            r = m << (-s);
        else if (s >= 64)
            r = 64'd0;
        else
        begin
            rem = m & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            r = m >> s;
            if (rem > half || (rem == half && r[0]))
                r++;
        end
        bits = (64'(q + 149) << 23) + r;
        if (bits >= 64'h7F80_0000)
            bits = 64'h7F80_0000;
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [63:0] sig_of(logic [31:0] v);
        return (v[30:23] == 8'd0) ? {41'd0, v[22:0]} : {40'd0, 1'b1, v[22:0]};
    endfunction

    function automatic int exp_of(logic [31:0] v);
        return (v[30:23] == 8'd0) ? 1 : int'(v[30:23]);
    endfunction

    function automatic logic [31:0] mul_f32(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = sig_of(a);
        mb = sig_of(b);
        if (ma == 0 || mb == 0)
            return {a[31] ^ b[31], 31'd0};
        return round_f32(a[31] ^ b[31], ma * mb, exp_of(a) + exp_of(b) - 300);
    endfunction

    function automatic logic [31:0] add_f32(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        logic [31:0] t;
        int          d;
        logic        sgn;
        if (exp_of(b) > exp_of(a))
        begin
            t = a;
            a = b;
            b = t;
        end
        ma = sig_of(a) << 3;
        mb = sig_of(b) << 3;
        d = exp_of(a) - exp_of(b);
        if (d >= 40)
            mb = {63'd0, mb != 64'd0};
        else if (d > 0)
            mb = (mb >> d) | {63'd0, (mb & ((64'd1 << d) - 64'd1)) != 64'd0};
        if (a[31] == b[31])
        begin
            m = ma + mb;
            sgn = a[31];
        end
        else if (ma >= mb)
        begin
            m = ma - mb;
            sgn = a[31];
        end
        else
        begin
            m = mb - ma;
            sgn = b[31];
        end
        if (m == 0)
            return {(a[31] == b[31]) ? a[31] : 1'b0, 31'd0};
        return round_f32(sgn, m, exp_of(a) - 153);
    endfunction

    function automatic logic [31:0] tanh_f32(logic [31:0] xin);
        logic [31:0] x;
        logic [31:0] y;
        x = xin & MAG_MASK;
        y = ONE_BITS;
        for (int i = 0; i < SEGMENT_COUNT; i++)
        begin
            if (x >= SEG_LO[i] && x < SEG_HI[i])
            begin
                y = add_f32(mul_f32(SEG_A[i], mul_f32(x, x)),
                            add_f32(SEG_C[i], mul_f32(x, SEG_B[i])));
                break;
            end
        end
        return {y[31] ^ xin[31], y[30:0]};
    endfunction

    // one item through the handshake; want of NO_CHECK means use the predictor
    // valid stays up after the item so back to back items need no gap
    task automatic send_item(input logic [31:0] x, input logic [31:0] want, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        x_bits   <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tanh_queue.push_back(want == NO_CHECK ? tanh_f32(x) : want);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_x();
        int          kind;
        int          seg;
        logic [31:0] v;
        logic [31:0] w;
        kind = $urandom_range(0, 9);
        v = $urandom();
        if (kind < 6)
        begin
            // land inside a segment
            seg = $urandom_range(0, SEGMENT_COUNT - 1);
            w = SEG_LO[seg] + ($urandom() % (SEG_HI[seg] - SEG_LO[seg]));
            v[30:0] = w[30:0];
        end
        else if (kind == 6)
        begin
            seg = $urandom_range(0, SEGMENT_COUNT - 1);
            w = $urandom_range(0, 1) ? SEG_LO[seg] : SEG_HI[seg] - 32'd1;
            v[30:0] = w[30:0];
        end
        else if (kind == 7)
            v[30:0] = {8'd0, v[22:0]};
        return v;
    endfunction

    // receiver: random stall per item, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (60)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall)
                    @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tanh_queue.size() == 0)
                report_mismatch("unexpected y_bits", y_bits, 32'h0);
            else
            begin
                if (y_bits !== tanh_queue[0])
                    report_mismatch("y_bits", y_bits, tanh_queue[0]);
                void'(tanh_queue.pop_front());
            end
        end
    end

    initial
    begin
        logic [31:0] stim_x   [] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                                     32'h807F_FFFF, 32'h3B23_D709, 32'h3B23_D70A,
                                     32'h3F80_0000, 32'hBF80_0000, 32'h4107_FFFF,
                                     32'h4108_0000, 32'hC108_0000, 32'h7F7F_FFFF,
                                     32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                                     32'hFFFF_FFFF, 32'h40D8_0000, 32'h3E00_0000};
        logic [31:0] stim_want[] = '{NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK,
                                     NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK,
                                     32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000,
                                     32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000,
                                     32'hBF80_0000, NO_CHECK, NO_CHECK};
        int wait_cycles;
        n_errors  = 0;
        send_done = 1'b0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        x_bits    = 32'h0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_x[i])
            send_item(stim_x[i], stim_want[i], 1'b1);
        in_valid <= 1'b0;

        // sender pauses until the pipe is empty
        while (tanh_queue.size() != 0)
            @(negedge clk);

        // receiver holds off while items keep coming back to back
        long_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(random_x(), NO_CHECK, 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
            send_item(random_x(), NO_CHECK, ($urandom_range(0, 4) != 0) && (i % 300 > 40));
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (tanh_queue.size() != 0 && wait_cycles < 100_000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (n_errors == 0 && tanh_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
